FILE: src/rcf_pkg.sv
// Shared constants and types for the real/complex FIR filter.
package rcf_pkg;

  localparam int RCF_MAX_TAPS     = 64;
  localparam int RCF_SAMPLE_WIDTH = 16;
  localparam int RCF_OUT_W        = 38;
  localparam int RCF_TAP_IDX_W    = 6;
  localparam int RCF_CNT_REG_W    = 7;
  localparam int RCF_CFG_ADDR_W   = 1;
  localparam int RCF_CFG_DATA_W   = 7;

  localparam logic RCF_CMD_FILTER = 1'b0;
  localparam logic RCF_CMD_LOAD   = 1'b1;

  localparam logic [RCF_CFG_ADDR_W-1:0] RCF_CFG_NTAPS        = 1'b0;
  localparam logic [RCF_CFG_ADDR_W-1:0] RCF_CFG_COMPLEX_MODE = 1'b1;

  typedef struct packed {
    logic vld;  // operands present this cycle
    logic clr;  // zero the accumulators
  } rcf_mac_ctl_t;

endpackage

FILE: src/rcf_if.sv
// Valid/ready channel interfaces for the filter's input and result items.
interface rcf_in_if
  import rcf_pkg::*;
#(
  parameter int SW = RCF_SAMPLE_WIDTH
) ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [SW-1:0]     sample_re;
  logic signed [SW-1:0]     sample_im;
  logic [RCF_TAP_IDX_W-1:0] tap_index;
  logic signed [SW-1:0]     tap_re;
  logic signed [SW-1:0]     tap_im;

  modport source (output valid, cmd, sample_re, sample_im, tap_index, tap_re, tap_im,
                  input ready);
  modport sink   (input valid, cmd, sample_re, sample_im, tap_index, tap_re, tap_im,
                  output ready);
endinterface

interface rcf_out_if
  import rcf_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [RCF_OUT_W-1:0] out_re;
  logic signed [RCF_OUT_W-1:0] out_im;

  modport source (output valid, out_re, out_im, input ready);
  modport sink   (input valid, out_re, out_im, output ready);
endinterface

FILE: src/real_complex_fir_filter.sv
// Real/complex direct-form FIR filter with a loadable tap memory, top level.
//
// A tap-load item (cmd = load) writes one coefficient entry and returns
// nothing; an index of MAX_TAPS or more is dropped. A sample item pushes the
// sample into a circular delay-line RAM and then one shared complex
// multiply-accumulate unit walks the taps, one tap per cycle, up to the tap
// count clipped to MAX_TAPS; the pipeline then drains and the result moves
// to the output register once any earlier result there has been taken.
// The input is not ready while the taps are being walked. Each sample gives
// one result item: out_re/out_im are the exact sum in Q8.30, out_im is zero
// in real mode. In real mode the quadrature part of the sample is stored as
// zero and the imaginary tap parts are ignored. The delay line reads as zero
// from reset: a fill count marks which entries were written, so no clearing
// pass is needed. Tap entries must be written before they are used. The user
// must write the tap count and complex_mode through the cfg port (index 0
// and 1) only while the block is idle; the block does not enforce this.
// Changing them keeps the delay line. A finished result sits in an output
// register, so the next item is taken while the result still waits to be read.
module real_complex_fir_filter
  import rcf_pkg::*;
#(
  parameter int MAX_TAPS     = RCF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = RCF_SAMPLE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [RCF_CFG_ADDR_W-1:0] cfg_addr,
  input  logic [RCF_CFG_DATA_W-1:0] cfg_wdata,
  rcf_in_if.sink                    in_chan,
  rcf_out_if.source                 out_chan
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int AW  = $clog2(MAX_TAPS);
  localparam int CWM = $clog2(MAX_TAPS + 1);
  localparam int LW  = (CWM > RCF_CNT_REG_W) ? CWM : RCF_CNT_REG_W;
  localparam int IW  = ((AW > RCF_TAP_IDX_W) ? AW : RCF_TAP_IDX_W) + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [RCF_CNT_REG_W-1:0] ntaps_r;
  logic                     cplx_r;
  logic [AW-1:0]            wp_r, wp_nxt;
  logic [AW-1:0]            rp_r, rp_nxt;
  logic [LW-1:0]            fill_r, fill_nxt;
  logic [LW-1:0]            k_r, k_nxt;
  logic                     s1_vld_r, s1_vld_nxt;
  logic                     s1_live_r, s1_live_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic [RCF_OUT_W-1:0]     out_re_r, out_im_r;

  logic                     in_acc;
  logic                     filt_acc;
  logic                     load_acc;
  logic [AW-1:0]            wp_inc;
  logic [AW-1:0]            rp_dec;
  logic [LW-1:0]            tap_lim;
  logic                     issue;
  logic                     out_load;
  logic [IW-1:0]            tix;
  logic                     tix_ok;

  logic [2*SW-1:0]          dly_wdata, dly_rdata;
  logic [2*SW-1:0]          coef_wdata, coef_rdata;
  logic signed [SW-1:0]     a_re, a_im, b_re, b_im;
  rcf_mac_ctl_t             mac_ctl;
  logic [RCF_OUT_W-1:0]     acc_re, acc_im;
  logic                     mac_busy;

  // Handshake.
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign filt_acc      = in_acc && (in_chan.cmd == RCF_CMD_FILTER);
  assign load_acc      = in_acc && (in_chan.cmd == RCF_CMD_LOAD);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntaps_r <= RCF_CNT_REG_W'(1);
      cplx_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        RCF_CFG_NTAPS:        ntaps_r <= cfg_wdata[RCF_CNT_REG_W-1:0];
        RCF_CFG_COMPLEX_MODE: cplx_r  <= cfg_wdata[0];
        default:              ;
      endcase
    end
  end

  // Clip the tap count to the depth of the tap memory.
  assign tap_lim = (LW'(ntaps_r) > LW'(MAX_TAPS)) ? LW'(MAX_TAPS) : LW'(ntaps_r);

  // Circular pointer arithmetic; the depth need not be a power of two.
  assign wp_inc = (wp_r == AW'(MAX_TAPS - 1)) ? '0 : wp_r + AW'(1);
  assign rp_dec = (rp_r == '0) ? AW'(MAX_TAPS - 1) : rp_r - AW'(1);

  // Tap load: drop indexes beyond the memory.
  assign tix    = IW'(in_chan.tap_index);
  assign tix_ok = (tix < IW'(MAX_TAPS));

  assign coef_wdata = {in_chan.tap_im, in_chan.tap_re};
  // Real mode stores the quadrature part as zero.
  assign dly_wdata  = {(cplx_r ? in_chan.sample_im : SW'(0)), in_chan.sample_re};

  rcf_ram #(.WIDTH(2 * SW), .DEPTH(MAX_TAPS)) u_dly_ram (
    .clk   (clk),
    .we    (filt_acc),
    .waddr (wp_inc),
    .wdata (dly_wdata),
    .raddr (rp_r),
    .rdata (dly_rdata)
  );

  rcf_ram #(.WIDTH(2 * SW), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (load_acc && tix_ok),
    .waddr (tix[AW-1:0]),
    .wdata (coef_wdata),
    .raddr (k_r[AW-1:0]),
    .rdata (coef_rdata)
  );

  // Operands: delay entries past the fill count are the zero prefix; in real
  // mode the quadrature part is ignored even if left over from complex mode.
  assign a_re = s1_live_r ? $signed(dly_rdata[SW-1:0]) : SW'(0);
  assign a_im = (s1_live_r && cplx_r) ? $signed(dly_rdata[2*SW-1:SW]) : SW'(0);
  assign b_re = $signed(coef_rdata[SW-1:0]);
  assign b_im = $signed(coef_rdata[2*SW-1:SW]);

  assign mac_ctl = '{vld: s1_vld_r, clr: filt_acc};

  rcf_cmac #(.SW(SW)) u_cmac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_re   (a_re),
    .a_im   (a_im),
    .b_re   (b_re),
    .b_im   (b_im),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .busy   (mac_busy)
  );

  // Sequencer: issue one tap per cycle, drain the pipeline, hand off result.
  assign issue    = (state_r == ST_RUN) && (k_r < tap_lim);
  assign out_load = (state_r == ST_DONE) && (!out_vld_r || out_chan.ready);

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    fill_nxt    = fill_r;
    k_nxt       = k_r;
    s1_vld_nxt  = issue;
    s1_live_nxt = (k_r < fill_r);
    out_vld_nxt = out_vld_r;

    if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (filt_acc) begin
          wp_nxt    = wp_inc;
          rp_nxt    = wp_inc;
          fill_nxt  = (fill_r == LW'(MAX_TAPS)) ? fill_r : fill_r + LW'(1);
          k_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          k_nxt  = k_r + LW'(1);
          rp_nxt = rp_dec;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_r && !mac_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wp_r      <= '0;
      rp_r      <= '0;
      fill_r    <= '0;
      k_r       <= '0;
      s1_vld_r  <= 1'b0;
      s1_live_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      fill_r    <= fill_nxt;
      k_r       <= k_nxt;
      s1_vld_r  <= s1_vld_nxt;
      s1_live_r <= s1_live_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Output register: hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re_r <= acc_re;
      out_im_r <= cplx_r ? acc_im : '0;
    end
  end

  assign out_chan.valid  = out_vld_r;
  assign out_chan.out_re = $signed(out_re_r);
  assign out_chan.out_im = $signed(out_im_r);

endmodule

FILE: src/rcf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module rcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rcf_cmac.sv
// Shared complex multiply-accumulate unit: registered products, then accumulate.
module rcf_cmac
  import rcf_pkg::*;
#(
  parameter int SW = RCF_SAMPLE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcf_mac_ctl_t         ctl,
  input  logic signed [SW-1:0] a_re,
  input  logic signed [SW-1:0] a_im,
  input  logic signed [SW-1:0] b_re,
  input  logic signed [SW-1:0] b_im,
  output logic [RCF_OUT_W-1:0] acc_re,
  output logic [RCF_OUT_W-1:0] acc_im,
  output logic                 busy
);

  localparam int PW = 2 * SW;
  localparam int EW = (PW > RCF_OUT_W) ? PW : RCF_OUT_W;

  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                 vld_r;
  logic [RCF_OUT_W-1:0] acc_re_r, acc_im_r;
  logic signed [EW-1:0] rr_e, ii_e, ri_e, ir_e;

  // Stage 1: four products in parallel.
  always_ff @(posedge clk) begin
    p_rr_r <= a_re * b_re;
    p_ii_r <= a_im * b_im;
    p_ri_r <= a_re * b_im;
    p_ir_r <= a_im * b_re;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.vld;
    end
  end

  // Sign-extend (or wrap) each product to the output width.
  assign rr_e = EW'(p_rr_r);
  assign ii_e = EW'(p_ii_r);
  assign ri_e = EW'(p_ri_r);
  assign ir_e = EW'(p_ir_r);

  // Stage 2: accumulate modulo 2^OUT_W.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (vld_r) begin
      acc_re_r <= acc_re_r + rr_e[RCF_OUT_W-1:0] - ii_e[RCF_OUT_W-1:0];
      acc_im_r <= acc_im_r + ri_e[RCF_OUT_W-1:0] + ir_e[RCF_OUT_W-1:0];
    end
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;
  assign busy   = vld_r;

endmodule

FILE: sim/rcf_fir_checker.sv
// Watches the filter's channels, predicts every result item and compares.
`timescale 1ns / 1ps

module rcf_fir_checker
  import rcf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [RCF_CFG_ADDR_W-1:0] cfg_addr,
  input  logic [RCF_CFG_DATA_W-1:0] cfg_wdata,
  rcf_in_if                         in_mon,
  rcf_out_if                        out_mon,
  output int                        open_sums,
  output int                        fail_count
);

  typedef struct packed {
    logic signed [RCF_OUT_W-1:0] re;
    logic signed [RCF_OUT_W-1:0] im;
  } fir_sum_t;

  logic signed [RCF_SAMPLE_WIDTH-1:0] hist_re [RCF_MAX_TAPS];
  logic signed [RCF_SAMPLE_WIDTH-1:0] hist_im [RCF_MAX_TAPS];
  logic signed [RCF_SAMPLE_WIDTH-1:0] coef_re [RCF_MAX_TAPS];
  logic signed [RCF_SAMPLE_WIDTH-1:0] coef_im [RCF_MAX_TAPS];
  logic [RCF_CNT_REG_W-1:0]           taps_used;
  logic                               iq_mode;
  fir_sum_t                           sums_q [$];
  int                                 misses;

  initial begin
    open_sums  = 0;
    fail_count = 0;
    misses     = 0;
  end

  // Shift the new sample into the history and form the dot product.
  function automatic fir_sum_t shift_and_sum(logic signed [RCF_SAMPLE_WIDTH-1:0] s_re,
                                             logic signed [RCF_SAMPLE_WIDTH-1:0] s_im);
    fir_sum_t r;
    longint   acc_re;
    longint   acc_im;
    int       n;
    for (int k = RCF_MAX_TAPS - 1; k > 0; k--) begin
      hist_re[k] = hist_re[k-1];
      hist_im[k] = hist_im[k-1];
    end
    hist_re[0] = s_re;
    hist_im[0] = iq_mode ? s_im : '0;
    n = (taps_used > RCF_MAX_TAPS) ? RCF_MAX_TAPS : int'(taps_used);
    acc_re = 0;
    acc_im = 0;
    for (int k = 0; k < n; k++) begin
      if (iq_mode) begin
        acc_re += longint'(hist_re[k]) * longint'(coef_re[k])
                - longint'(hist_im[k]) * longint'(coef_im[k]);
        acc_im += longint'(hist_re[k]) * longint'(coef_im[k])
                + longint'(hist_im[k]) * longint'(coef_re[k]);
      end else begin
        acc_re += longint'(hist_re[k]) * longint'(coef_re[k]);
      end
    end
    r.re = acc_re[RCF_OUT_W-1:0];
    r.im = iq_mode ? acc_im[RCF_OUT_W-1:0] : '0;
    return r;
  endfunction

  function automatic void note_miss(string what, longint want, longint got);
    misses++;
    if (misses <= 10)
      $display("%t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin
    fir_sum_t want;
    if (!rst_n) begin
      for (int k = 0; k < RCF_MAX_TAPS; k++) begin
        hist_re[k] = '0;
        hist_im[k] = '0;
        coef_re[k] = '0;
        coef_im[k] = '0;
      end
      taps_used = 7'd1;
      iq_mode   = 1'b0;
      sums_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          RCF_CFG_NTAPS:        taps_used = cfg_wdata[RCF_CNT_REG_W-1:0];
          RCF_CFG_COMPLEX_MODE: iq_mode   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.cmd == RCF_CMD_LOAD) begin
          coef_re[in_mon.tap_index] = in_mon.tap_re;
          coef_im[in_mon.tap_index] = in_mon.tap_im;
        end else begin
          sums_q.push_back(shift_and_sum(in_mon.sample_re, in_mon.sample_im));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (sums_q.size() == 0) begin
          note_miss("unexpected result, out_re", 0, longint'(out_mon.out_re));
        end else begin
          want = sums_q.pop_front();
          if (out_mon.out_re !== want.re)
            note_miss("out_re", longint'(want.re), longint'(out_mon.out_re));
          if (out_mon.out_im !== want.im)
            note_miss("out_im", longint'(want.im), longint'(out_mon.out_im));
        end
      end
    end
    open_sums  <= sums_q.size();
    fail_count <= misses;
  end

endmodule

FILE: sim/real_complex_fir_filter_tb.sv
// Stimulus, clock, reset and verdict for the real/complex FIR filter.
`timescale 1ns / 1ps

module real_complex_fir_filter_tb;
  import rcf_pkg::*;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [RCF_CFG_ADDR_W-1:0] cfg_addr;
  logic [RCF_CFG_DATA_W-1:0] cfg_wdata;
  int                        open_sums;
  int                        fail_count;
  int                        stall_left = 0;
  bit                        calm = 1'b0;  // no idling on either side when set

  rcf_in_if  in_chan ();
  rcf_out_if out_chan ();

  real_complex_fir_filter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rcf_fir_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .open_sums (open_sums),
    .fail_count(fail_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: hold ready low in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= $urandom_range(0, 4);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Q1.15 value biased toward the extremes and zero.
  function automatic logic signed [15:0] rand_q15();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return 16'($signed($urandom_range(0, 15)) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  // Present one item, after an optional idle burst, and hold it until taken.
  task automatic send_item(input logic cmd,
                           input logic signed [15:0] s_re, s_im,
                           input logic [RCF_TAP_IDX_W-1:0] idx,
                           input logic signed [15:0] t_re, t_im);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.cmd       <= cmd;
    in_chan.sample_re <= s_re;
    in_chan.sample_im <= s_im;
    in_chan.tap_index <= idx;
    in_chan.tap_re    <= t_re;
    in_chan.tap_im    <= t_im;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Unused fields of each item get random noise.
  task automatic send_sample(input logic signed [15:0] s_re, s_im);
    send_item(RCF_CMD_FILTER, s_re, s_im, RCF_TAP_IDX_W'($urandom()),
              16'($urandom()), 16'($urandom()));
  endtask

  task automatic load_tap(input logic [RCF_TAP_IDX_W-1:0] idx,
                          input logic signed [15:0] t_re, t_im);
    send_item(RCF_CMD_LOAD, 16'($urandom()), 16'($urandom()), idx, t_re, t_im);
  endtask

  // Drop valid, let every pending result drain plus a full tap walk, then
  // write both registers while the block is idle.
  task automatic reconfigure(input logic [RCF_CNT_REG_W-1:0] taps, input logic iq);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (open_sums != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= RCF_CFG_NTAPS;
    cfg_wdata <= RCF_CFG_DATA_W'(taps);
    @(posedge clk);
    cfg_addr  <= RCF_CFG_COMPLEX_MODE;
    cfg_wdata <= RCF_CFG_DATA_W'(iq);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly samples with the odd tap reload mixed in.
  task automatic run_phase(input logic [RCF_CNT_REG_W-1:0] taps, input logic iq,
                           input int n_items);
    reconfigure(taps, iq);
    repeat (n_items) begin
      if ($urandom_range(0, 7) == 0)
        load_tap(RCF_TAP_IDX_W'($urandom_range(0, RCF_MAX_TAPS - 1)), rand_q15(), rand_q15());
      else
        send_sample(rand_q15(), rand_q15());
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_addr          = '0;
    cfg_wdata         = '0;
    in_chan.valid     = 1'b0;
    in_chan.cmd       = RCF_CMD_FILTER;
    in_chan.sample_re = '0;
    in_chan.sample_im = '0;
    in_chan.tap_index = '0;
    in_chan.tap_re    = '0;
    in_chan.tap_im    = '0;
    out_chan.ready    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole tap memory first so no unwritten entry is ever read;
    // alternate full-scale values so the widest sums show up.
    for (int k = 0; k < RCF_MAX_TAPS; k++) begin
      if (k % 2 == 0)
        load_tap(RCF_TAP_IDX_W'(k), 16'sh8000, 16'sh7FFF);
      else
        load_tap(RCF_TAP_IDX_W'(k), 16'sh7FFF, 16'sh8000);
    end

    // Reset settings: one real tap, quadrature input ignored.
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);

    // Full complex filter with extreme samples.
    reconfigure(7'd64, 1'b1);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh0001, 16'shFFFF);
    load_tap(6'd0, 16'sh7FFF, 16'sh8000);
    load_tap(6'd63, 16'sh8000, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh0001);

    // No taps in use: both parts come out zero.
    reconfigure(7'd0, 1'b1);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh8000);

    // Count above the memory size clips; real mode keeps the old history.
    reconfigure(7'd127, 1'b0);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);

    // Random part across settings, extremes included.
    run_phase(7'd64, 1'b1, 200);
    run_phase(7'd1, 1'b0, 200);
    run_phase(7'($urandom_range(2, 16)), 1'b1, 200);
    run_phase(7'd127, 1'b0, 200);
    run_phase(7'd0, 1'b1, 200);
    run_phase(7'($urandom_range(2, 63)), 1'b0, 200);
    run_phase(7'($urandom_range(2, 63)), 1'b1, 200);
    calm = 1'b1;
    run_phase(7'($urandom_range(1, 64)), 1'($urandom()), 200);

    // Drain the last results and allow a tap walk for anything stray.
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (open_sums != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("[real_complex_fir_filter] OK");
    end else begin
      $display("[real_complex_fir_filter] ERROR");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #1_500_000;
    $display("[real_complex_fir_filter] ERROR");
    $finish;
  end

endmodule
